// ===== hdl/ceg_pkg.sv =====
// Shared types and constants for the color effect generator.
// No dependencies; used by every module under hdl.
package ceg_pkg;

  localparam int PhaseFracBitsDef = 16;
  localparam int StepWidth        = 17;
  localparam int ColorWidth       = 24;
  localparam int ChanWidth        = 8;

  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_FADE    = 2'd1,
    MODE_RAINBOW = 2'd2
  } effect_mode_e;

  typedef enum logic [1:0] {
    REG_EFFECT_MODE  = 2'd0,
    REG_STATIC_COLOR = 2'd1,
    REG_FADE_COLOR_A = 2'd2,
    REG_FADE_COLOR_B = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [ColorWidth-1:0] static_color;
    logic [ColorWidth-1:0] fade_color_a;
    logic [ColorWidth-1:0] fade_color_b;
  } cfg_t;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } rgb_t;

endpackage

// ===== hdl/ceg_phase.sv =====
// Ping-pong phase register with direction flag and saturation.
// Depends on ceg_pkg.
module ceg_phase #(
  parameter int PHASE_FRAC_BITS = ceg_pkg::PhaseFracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  advance_i,
  input  logic [ceg_pkg::StepWidth-1:0]         time_step_i,
  output logic signed [PHASE_FRAC_BITS+1:0]     phase_o
);

  localparam int PW = PHASE_FRAC_BITS + 2;
  localparam int SW = PHASE_FRAC_BITS + 1;
  localparam int XW = PHASE_FRAC_BITS + 3;
  localparam logic signed [PW-1:0] PhOne = {2'b01, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] PhMax = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PhMin = {1'b1, {(PW-1){1'b0}}};

  logic signed [PW-1:0] phase_q, phase_d;
  logic                 down_q, down_d;
  logic [SW-1:0]        step;
  logic signed [XW-1:0] phase_x, step_x, sum;

  if (PHASE_FRAC_BITS >= 16) begin : g_step_up
    assign step = SW'(time_step_i) << (PHASE_FRAC_BITS - 16);
  end else begin : g_step_dn
    assign step = SW'(time_step_i >> (16 - PHASE_FRAC_BITS));
  end

  always_comb begin
    if (phase_q >= PhOne) begin
      down_d = 1'b1;
    end else if (phase_q <= 0) begin
      down_d = 1'b0;
    end else begin
      down_d = down_q;
    end
    phase_x = XW'(phase_q);
    step_x  = $signed({2'b00, step});
    sum     = down_d ? (phase_x - step_x) : (phase_x + step_x);
    if (sum[XW-1] != sum[XW-2]) begin
      phase_d = sum[XW-1] ? PhMin : PhMax;
    end else begin
      phase_d = sum[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      down_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      down_q  <= down_d;
    end
  end

  assign phase_o = phase_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(phase_q) && $stable(down_q))
    else $error("phase moved without a transaction");

  a_turn_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (phase_q >= PhOne) |=> down_q)
    else $error("phase did not turn down at one");

  a_turn_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (phase_q <= 0) |=> !down_q)
    else $error("phase did not turn up at zero");

  a_up_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !down_d && (phase_q != PhMax) |=> phase_q >= $past(phase_q))
    else $error("phase fell while counting up");

endmodule

// ===== hdl/ceg_color.sv =====
// Color datapath: static, fade blend and six-sector rainbow from the phase.
// Depends on ceg_pkg.
module ceg_color #(
  parameter int PHASE_FRAC_BITS = ceg_pkg::PhaseFracBitsDef
) (
  input  logic signed [PHASE_FRAC_BITS+1:0] phase_i,
  input  ceg_pkg::cfg_t                     cfg_i,
  output ceg_pkg::rgb_t                     rgb_o
);

  localparam int P   = PHASE_FRAC_BITS;
  localparam int PRW = P + 11;
  localparam int VW  = P + 12;
  localparam int HW  = P + 3;
  localparam logic [P:0] PhOneU = {1'b1, {P{1'b0}}};

  logic [2:0][7:0]        fade;
  logic [HW-1:0]          hue;
  logic [2:0]             sector;
  logic [P-1:0]           frac_t;
  logic [P:0]             x_lvl;
  logic [P+8:0]           x_scaled;
  logic [7:0]             xs;
  ceg_pkg::rgb_t          bow;

  for (genvar k = 0; k < 3; k++) begin : g_fade
    logic [7:0]           ch_a, ch_b;
    logic signed [8:0]    diff;
    logic signed [PRW-1:0] prod;
    logic signed [VW-1:0] base, v;

    assign ch_a = cfg_i.fade_color_a[8*k +: 8];
    assign ch_b = cfg_i.fade_color_b[8*k +: 8];
    assign diff = $signed({1'b0, ch_a}) - $signed({1'b0, ch_b});
    assign prod = PRW'(diff) * PRW'(phase_i);
    assign base = VW'($signed({1'b0, ch_b})) <<< P;
    assign v    = base + VW'(prod);

    always_comb begin
      if (v[VW-1]) begin
        fade[k] = 8'd0;
      end else if (v[VW-2:P+8] != '0) begin
        fade[k] = 8'd255;
      end else begin
        fade[k] = v[P+7:P];
      end
    end
  end

  always_comb begin
    hue      = {3'b000, phase_i[P-1:0]} * HW'(6);
    sector   = hue[HW-1:P];
    frac_t   = hue[P-1:0];
    x_lvl    = sector[0] ? (PhOneU - {1'b0, frac_t}) : {1'b0, frac_t};
    x_scaled = ({x_lvl, 8'd0} - (P+9)'(x_lvl));
    xs       = x_scaled[P+7:P];
    bow      = '0;
    if (!phase_i[P+1]) begin
      case (sector)
        3'd0: begin
          bow.red = 8'd255; bow.green = xs;
        end
        3'd1: begin
          bow.red = xs; bow.green = 8'd255;
        end
        3'd2: begin
          bow.green = 8'd255; bow.blue = xs;
        end
        3'd3: begin
          bow.green = xs; bow.blue = 8'd255;
        end
        3'd4: begin
          bow.red = xs; bow.blue = 8'd255;
        end
        default: begin
          bow.red = 8'd255; bow.blue = xs;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_i.mode)
      ceg_pkg::MODE_STATIC: begin
        rgb_o.red   = cfg_i.static_color[23:16];
        rgb_o.green = cfg_i.static_color[15:8];
        rgb_o.blue  = cfg_i.static_color[7:0];
      end
      ceg_pkg::MODE_FADE: begin
        rgb_o.red   = fade[2];
        rgb_o.green = fade[1];
        rgb_o.blue  = fade[0];
      end
      ceg_pkg::MODE_RAINBOW: begin
        rgb_o = bow;
      end
      default: begin
        rgb_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/color_effect_generator_top.sv =====
// Color effect generator: phase update on each tick, then one RGB result.
// Throughput: one transaction per cycle while the output is not stalled.
// The phase register is the input stage, the RGB register the output stage,
// with one color datapath between them.
// Reset clears the phase, its direction, all configuration registers and valids.
// Depends on ceg_pkg, ceg_phase and ceg_color.
module color_effect_generator_top #(
  parameter int PHASE_FRAC_BITS = ceg_pkg::PhaseFracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [ceg_pkg::ColorWidth-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ceg_pkg::StepWidth-1:0]     time_step_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ceg_pkg::ChanWidth-1:0]     red_o,
  output logic [ceg_pkg::ChanWidth-1:0]     green_o,
  output logic [ceg_pkg::ChanWidth-1:0]     blue_o
);

  ceg_pkg::cfg_t                    cfg_q;
  ceg_pkg::rgb_t                    rgb_d, rgb_q;
  logic                             ph_valid_q, out_valid_q;
  logic                             in_fire, ph_adv;
  logic signed [PHASE_FRAC_BITS+1:0] phase;

  assign ph_adv     = ph_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !ph_valid_q || ph_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ceg_pkg::REG_EFFECT_MODE:  cfg_q.mode         <= cfg_data_i[1:0];
        ceg_pkg::REG_STATIC_COLOR: cfg_q.static_color <= cfg_data_i;
        ceg_pkg::REG_FADE_COLOR_A: cfg_q.fade_color_a <= cfg_data_i;
        ceg_pkg::REG_FADE_COLOR_B: cfg_q.fade_color_b <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ceg_phase #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (in_fire),
    .time_step_i(time_step_i),
    .phase_o    (phase)
  );

  ceg_color #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_color (
    .phase_i(phase),
    .cfg_i  (cfg_q),
    .rgb_o  (rgb_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ph_valid_q  <= in_fire || (ph_valid_q && !ph_adv);
      out_valid_q <= ph_adv || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_adv) begin
      rgb_q <= rgb_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = rgb_q.red;
  assign green_o     = rgb_q.green;
  assign blue_o      = rgb_q.blue;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_valid_q && out_valid_q && !out_ready_i |=> ph_valid_q)
    else $error("pending phase transaction lost");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_adv |=> out_valid_q)
    else $error("result register not loaded");

  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are full");

endmodule
